### rtl/tsw_pkg.sv
// ----------------------------------------------------------------------------
// tsw_pkg
// Shared types, codes and reset defaults for the thread stall watchdog.
// ----------------------------------------------------------------------------
package tsw_pkg;

   // Default sizing
   localparam int FIFO_DEPTH_DEFAULT = 32;
   localparam int TIME_WIDTH_DEFAULT = 32;

   // Fixed field widths
   localparam int CNT_WIDTH      = 31;
   localparam int OP_WIDTH       = 2;
   localparam int EVT_WIDTH      = 32;
   localparam int PERIOD_WIDTH   = 4;
   localparam int TIMEOUT_WIDTH  = 16;
   localparam int HOLDOFF_WIDTH  = 6;
   localparam int REPEAT_WIDTH   = 4;
   localparam int REPORT_WIDTH   = 2;
   localparam int RSP_DATA_WIDTH = 16;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 16;

   // Register reset values
   localparam logic [PERIOD_WIDTH-1:0]  NORMAL_PERIOD_RST  = 4'd3;
   localparam logic [PERIOD_WIDTH-1:0]  WARNING_PERIOD_RST = 4'd2;
   localparam logic [PERIOD_WIDTH-1:0]  FREEZE_PERIOD_RST  = 4'd1;
   localparam logic [TIMEOUT_WIDTH-1:0] INPUT_TIMEOUT_RST  = 16'd5000;
   localparam logic [HOLDOFF_WIDTH-1:0] ALERT_HOLDOFF_RST  = 6'd20;
   localparam logic [REPEAT_WIDTH-1:0]  FREEZE_REPEAT_RST  = 4'd5;
   localparam logic                     TARGET_ATTACH_RST  = 1'b1;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_CHECK     = 2'd0,
      OP_HEARTBEAT = 2'd1,
      OP_PUSH      = 2'd2,
      OP_POP       = 2'd3
   } op_type;

   typedef enum logic [REPORT_WIDTH-1:0] {
      REPORT_NONE      = 2'd0,
      REPORT_WARNING   = 2'd1,
      REPORT_FREEZE    = 2'd2,
      REPORT_RECOVERED = 2'd3
   } report_type;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      REG_NORMAL_PERIOD  = 3'd0,
      REG_WARNING_PERIOD = 3'd1,
      REG_FREEZE_PERIOD  = 3'd2,
      REG_INPUT_TIMEOUT  = 3'd3,
      REG_ALERT_HOLDOFF  = 3'd4,
      REG_FREEZE_REPEAT  = 3'd5,
      REG_TARGET_ATTACH  = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_NORMAL  = 3'b001,
      ST_WARNING = 3'b010,
      ST_FREEZE  = 3'b100
   } watch_state_type;

   typedef struct packed {
      logic                    push_dropped;
      logic [PERIOD_WIDTH-1:0] next_check_delay;
      logic                    events_flushed;
      logic                    raise_alert;
      report_type              report_code;
      logic                    stall_seen;
      logic                    probe_request;
   } rsp_type;

endpackage

### rtl/tsw_ram.sv
// ----------------------------------------------------------------------------
// tsw_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/thread_stall_watchdog.sv
// Output: results are registered; requests stall while the skid stage is full.
// Throughput: one request per cycle; the pending-event RAM is re-read at the
// next head address every cycle, with a write-to-read bypass, so a check can
// use the oldest timestamp in the same cycle it is accepted.
// Reset: synchronous; clears control state and loads register defaults.
// The event RAM is not cleared; entries are read only after being written.
// ----------------------------------------------------------------------------
// thread_stall_watchdog
// Heartbeat watchdog with NORMAL/WARNING/FREEZE escalation, alert hold-off
// and a pending-event FIFO flushed on a stall once its oldest entry times out.
// ----------------------------------------------------------------------------
module thread_stall_watchdog #(
   parameter int FIFO_DEPTH = tsw_pkg::FIFO_DEPTH_DEFAULT,
   parameter int TIME_WIDTH = tsw_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tsw_pkg::EVT_WIDTH-1:0]       req_tdata,   // [31:0] event_time
   input  logic [tsw_pkg::OP_WIDTH-1:0]        req_tuser,   // [1:0] operation
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] probe_request, [1] stall_seen, [3:2] report_code, [4] raise_alert,
   // [5] events_flushed, [9:6] next_check_delay, [10] push_dropped, [15:11] 0
   output logic [tsw_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // configuration
   input  logic                                csr_we,
   input  logic [tsw_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [tsw_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FW = $clog2(FIFO_DEPTH + 1);
   localparam int SW = FW + 1;
   localparam int PAD_WIDTH = tsw_pkg::RSP_DATA_WIDTH - $bits(tsw_pkg::rsp_type);

   // configuration registers
   logic [tsw_pkg::PERIOD_WIDTH-1:0]  normal_period_ff;
   logic [tsw_pkg::PERIOD_WIDTH-1:0]  warning_period_ff;
   logic [tsw_pkg::PERIOD_WIDTH-1:0]  freeze_period_ff;
   logic [tsw_pkg::TIMEOUT_WIDTH-1:0] input_timeout_ff;
   logic [tsw_pkg::HOLDOFF_WIDTH-1:0] alert_holdoff_ff;
   logic [tsw_pkg::REPEAT_WIDTH-1:0]  freeze_repeat_ff;
   logic                              target_attached_ff;

   // watchdog state
   tsw_pkg::watch_state_type          state_ff, state_in;
   logic [tsw_pkg::CNT_WIDTH-1:0]     probes_ff, probes_in;
   logic [tsw_pkg::CNT_WIDTH-1:0]     heartbeats_ff, heartbeats_in;
   logic [tsw_pkg::REPEAT_WIDTH-1:0]  repeat_cnt_ff, repeat_cnt_in;
   logic                              alert_allowed_ff, alert_allowed_in;
   logic [tsw_pkg::HOLDOFF_WIDTH-1:0] holdoff_cnt_ff, holdoff_cnt_in;
   logic [AW-1:0]                     head_ff, head_in;
   logic [FW-1:0]                     fill_ff, fill_in;

   // head-entry bypass
   logic                              fwd_valid_ff;
   logic [TIME_WIDTH-1:0]             fwd_data_ff;

   // output register and skid stage
   logic                              out_valid_ff, out_valid_in;
   tsw_pkg::rsp_type                  out_data_ff, out_data_in;
   logic                              skid_valid_ff, skid_valid_in;
   tsw_pkg::rsp_type                  skid_data_ff, skid_data_in;

   logic                              req_acc;
   logic                              out_take;
   tsw_pkg::op_type                   op;
   logic [TIME_WIDTH-1:0]             evt_time;
   logic [TIME_WIDTH-1:0]             head_time;
   logic [TIME_WIDTH-1:0]             rd_data;
   logic [TIME_WIDTH-1:0]             age;
   logic                              timed_out;
   logic                              fifo_full;
   logic [AW-1:0]                     head_next;
   logic [SW-1:0]                     wr_sum;
   logic [SW-1:0]                     wr_wrap;
   logic [AW-1:0]                     wr_addr;
   logic                              wr_en;
   logic                              stall;
   logic                              do_timeout;
   logic [tsw_pkg::HOLDOFF_WIDTH-1:0] holdoff_inc;
   logic [tsw_pkg::REPEAT_WIDTH-1:0]  repeat_inc;
   tsw_pkg::rsp_type                  res;

   assign req_tready = !skid_valid_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign out_take   = out_valid_ff && rsp_tready;
   assign op         = tsw_pkg::op_type'(req_tuser);
   assign evt_time   = TIME_WIDTH'(req_tdata);

   // ---------------------------------------------------------------- FIFO
   assign fifo_full = (fill_ff == FW'(FIFO_DEPTH));
   assign head_next = (head_ff == AW'(FIFO_DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign wr_sum    = SW'(head_ff) + SW'(fill_ff);
   assign wr_wrap   = (wr_sum >= SW'(FIFO_DEPTH)) ? wr_sum - SW'(FIFO_DEPTH) : wr_sum;
   assign wr_addr   = wr_wrap[AW-1:0];
   assign wr_en     = req_acc && (op == tsw_pkg::OP_PUSH) && !fifo_full;

   // RAM read port follows the next head so the oldest entry is ready
   tsw_ram #(
      .WIDTH (TIME_WIDTH),
      .DEPTH (FIFO_DEPTH)
   ) u_event_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (evt_time),
      .rd_addr (head_in),
      .rd_data (rd_data)
   );

   assign head_time = fwd_valid_ff ? fwd_data_ff : rd_data;
   assign age       = evt_time - head_time;
   assign timed_out = (fill_ff != '0) && (age > TIME_WIDTH'(input_timeout_ff));

   assign holdoff_inc = holdoff_cnt_ff + tsw_pkg::HOLDOFF_WIDTH'(1);
   assign repeat_inc  = repeat_cnt_ff + tsw_pkg::REPEAT_WIDTH'(1);
   assign stall       = (heartbeats_ff != probes_ff);

   // ---------------------------------------------------------------- update
   always_comb begin
      state_in         = state_ff;
      probes_in        = probes_ff;
      heartbeats_in    = heartbeats_ff;
      repeat_cnt_in    = repeat_cnt_ff;
      alert_allowed_in = alert_allowed_ff;
      holdoff_cnt_in   = holdoff_cnt_ff;
      head_in          = head_ff;
      fill_in          = fill_ff;
      do_timeout       = 1'b0;
      res              = '0;
      if (req_acc) begin
         unique case (op)
            tsw_pkg::OP_CHECK: begin
               res.stall_seen = stall;
               if (stall) begin
                  heartbeats_in = probes_ff;
               end
               if (probes_ff == '1) begin
                  probes_in     = '0;
                  heartbeats_in = '0;
               end
               if (target_attached_ff) begin
                  res.probe_request = 1'b1;
                  probes_in         = probes_in + tsw_pkg::CNT_WIDTH'(1);
               end
               res.next_check_delay = normal_period_ff;
               if (!stall) begin
                  if (state_ff == tsw_pkg::ST_FREEZE) begin
                     res.report_code = tsw_pkg::REPORT_RECOVERED;
                  end
                  repeat_cnt_in    = '0;
                  state_in         = tsw_pkg::ST_NORMAL;
                  alert_allowed_in = 1'b1;
                  holdoff_cnt_in   = '0;
               end else begin
                  unique case (state_ff)
                     tsw_pkg::ST_NORMAL: begin
                        res.report_code      = tsw_pkg::REPORT_WARNING;
                        state_in             = tsw_pkg::ST_WARNING;
                        res.next_check_delay = warning_period_ff;
                     end
                     tsw_pkg::ST_WARNING: begin
                        res.report_code      = tsw_pkg::REPORT_FREEZE;
                        state_in             = tsw_pkg::ST_FREEZE;
                        res.next_check_delay = freeze_period_ff;
                        do_timeout           = 1'b1;
                     end
                     default: begin
                        if (!alert_allowed_ff) begin
                           holdoff_cnt_in = holdoff_inc;
                           if (holdoff_inc >= alert_holdoff_ff) begin
                              alert_allowed_in = 1'b1;
                              holdoff_cnt_in   = '0;
                           end
                        end
                        repeat_cnt_in = repeat_inc;
                        if (repeat_inc >= freeze_repeat_ff) begin
                           res.report_code = tsw_pkg::REPORT_FREEZE;
                           repeat_cnt_in   = '0;
                        end
                        res.next_check_delay = freeze_period_ff;
                        do_timeout           = 1'b1;
                     end
                  endcase
               end
            end
            tsw_pkg::OP_HEARTBEAT: begin
               heartbeats_in = heartbeats_ff + tsw_pkg::CNT_WIDTH'(1);
            end
            tsw_pkg::OP_PUSH: begin
               if (fifo_full) begin
                  res.push_dropped = 1'b1;
               end else begin
                  fill_in = fill_ff + FW'(1);
               end
            end
            default: begin
               if (fill_ff != '0) begin
                  head_in = head_next;
                  fill_in = fill_ff - FW'(1);
               end
            end
         endcase
         // oldest pending event too old: flush, alert unless held off
         if (do_timeout && timed_out) begin
            if (alert_allowed_in) begin
               res.raise_alert  = 1'b1;
               alert_allowed_in = 1'b0;
               holdoff_cnt_in   = '0;
            end
            fill_in            = '0;
            res.events_flushed = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- output
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_acc) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_data_in  = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {PAD_WIDTH'(0), out_data_ff};

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         normal_period_ff   <= tsw_pkg::NORMAL_PERIOD_RST;
         warning_period_ff  <= tsw_pkg::WARNING_PERIOD_RST;
         freeze_period_ff   <= tsw_pkg::FREEZE_PERIOD_RST;
         input_timeout_ff   <= tsw_pkg::INPUT_TIMEOUT_RST;
         alert_holdoff_ff   <= tsw_pkg::ALERT_HOLDOFF_RST;
         freeze_repeat_ff   <= tsw_pkg::FREEZE_REPEAT_RST;
         target_attached_ff <= tsw_pkg::TARGET_ATTACH_RST;
      end else if (csr_we) begin
         case (csr_addr)
            tsw_pkg::REG_NORMAL_PERIOD: begin
               normal_period_ff <= csr_wdata[tsw_pkg::PERIOD_WIDTH-1:0];
            end
            tsw_pkg::REG_WARNING_PERIOD: begin
               warning_period_ff <= csr_wdata[tsw_pkg::PERIOD_WIDTH-1:0];
            end
            tsw_pkg::REG_FREEZE_PERIOD: begin
               freeze_period_ff <= csr_wdata[tsw_pkg::PERIOD_WIDTH-1:0];
            end
            tsw_pkg::REG_INPUT_TIMEOUT: begin
               input_timeout_ff <= csr_wdata[tsw_pkg::TIMEOUT_WIDTH-1:0];
            end
            tsw_pkg::REG_ALERT_HOLDOFF: begin
               alert_holdoff_ff <= csr_wdata[tsw_pkg::HOLDOFF_WIDTH-1:0];
            end
            tsw_pkg::REG_FREEZE_REPEAT: begin
               freeze_repeat_ff <= csr_wdata[tsw_pkg::REPEAT_WIDTH-1:0];
            end
            tsw_pkg::REG_TARGET_ATTACH: begin
               target_attached_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= tsw_pkg::ST_NORMAL;
         probes_ff        <= '0;
         heartbeats_ff    <= '0;
         repeat_cnt_ff    <= '0;
         alert_allowed_ff <= 1'b1;
         holdoff_cnt_ff   <= '0;
         head_ff          <= '0;
         fill_ff          <= '0;
         fwd_valid_ff     <= 1'b0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         probes_ff        <= probes_in;
         heartbeats_ff    <= heartbeats_in;
         repeat_cnt_ff    <= repeat_cnt_in;
         alert_allowed_ff <= alert_allowed_in;
         holdoff_cnt_ff   <= holdoff_cnt_in;
         head_ff          <= head_in;
         fill_ff          <= fill_in;
         // RAM read returns old contents when written the same cycle
         fwd_valid_ff     <= wr_en && (wr_addr == head_in);
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff  <= evt_time;
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // ---------------------------------------------------------------- checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(FIFO_DEPTH))
      else $error("event FIFO fill above depth");

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds data while output register is empty");

   a_write_not_full: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !fifo_full && (fill_in == fill_ff + FW'(1)))
      else $error("RAM write without matching fill increment");

   a_alert_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_acc && res.raise_alert) |=> !alert_allowed_ff && fill_ff == '0)
      else $error("alert did not arm hold-off and flush FIFO");

   a_flush_only_frozen: assert property (@(posedge clock) disable iff (reset)
      (req_acc && res.events_flushed) |=> state_ff == tsw_pkg::ST_FREEZE)
      else $error("events flushed outside freeze state");

endmodule
